/* design/pip_pkg.sv */
// Shared widths, codes and character constants of the prefixed integer parser.
package pip_pkg;

  localparam int VALUE_WIDTH  = 32;
  localparam int CHAR_WIDTH   = 8;
  localparam int STATUS_WIDTH = 2;
  localparam int DIGIT_WIDTH  = 4;
  // Guard bits above the value for a product with radix up to 16 plus a digit
  localparam int GUARD_WIDTH  = 4;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_HEX = 2'd2,
    RADIX_BIN = 2'd3
  } radix_t;

  typedef enum logic [STATUS_WIDTH-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_CHAR = 2'd1,
    STATUS_OVERFLOW = 2'd2,
    STATUS_EMPTY    = 2'd3
  } status_t;

  localparam logic [CHAR_WIDTH-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_WIDTH-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_WIDTH-1:0] CHAR_UC_A  = 8'h41;
  localparam logic [CHAR_WIDTH-1:0] CHAR_UC_B  = 8'h42;
  localparam logic [CHAR_WIDTH-1:0] CHAR_UC_F  = 8'h46;
  localparam logic [CHAR_WIDTH-1:0] CHAR_UC_X  = 8'h58;
  localparam logic [CHAR_WIDTH-1:0] CHAR_LC_A  = 8'h61;
  localparam logic [CHAR_WIDTH-1:0] CHAR_LC_B  = 8'h62;
  localparam logic [CHAR_WIDTH-1:0] CHAR_LC_F  = 8'h66;
  localparam logic [CHAR_WIDTH-1:0] CHAR_LC_X  = 8'h78;

endpackage

/* design/pip_char_if.sv */
// Character channel: one string byte per transfer.
interface pip_char_if;
  logic                           valid;
  logic                           ready;
  logic [pip_pkg::CHAR_WIDTH-1:0] character;

  modport source (output valid, output character, input ready);
  modport sink (input valid, input character, output ready);
endinterface

/* design/pip_result_if.sv */
// Result channel: parsed value and status, one transfer per terminated string.
interface pip_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [pip_pkg::VALUE_WIDTH-1:0] value;
  logic [pip_pkg::STATUS_WIDTH-1:0]    status;

  modport source (output valid, output value, output status, input ready);
  modport sink (input valid, input value, input status, output ready);
endinterface

/* design/prefixed_integer_parser.sv */
// Prefixed integer parser: string bytes in, signed value and status out.
//
//   channel  | dir | payload                 | transfer
//   ---------+-----+-------------------------+------------------------------
//   text     | in  | character[7:0]          | one byte; zero ends a string
//   result   | out | value[31:0], status[1:0]| one per zero byte
//
// One byte per cycle while no zero byte waits: each byte lands in an input
// register and is folded into the parse state by one shift-add-compare
// step. A zero byte loads the result register and clears the parse state
// in the same cycle. Reset clears the parse state and both valid flags.
// A stalled result blocks only a zero byte; digits keep flowing behind it.
module prefixed_integer_parser (
  input  logic               clk,
  input  logic               rst,
  pip_char_if.sink           text,
  pip_result_if.source       result
);

  localparam int VW = pip_pkg::VALUE_WIDTH;
  localparam int SW = pip_pkg::VALUE_WIDTH + pip_pkg::GUARD_WIDTH;

  // Input register
  logic                               in_valid;
  logic [pip_pkg::CHAR_WIDTH-1:0]     char_q;

  // Parse state
  logic [VW-1:0]                      acc;
  logic [VW-1:0]                      acc_next;
  pip_pkg::radix_t                    radix;
  pip_pkg::radix_t                    radix_next;
  logic [1:0]                         lzc;
  logic [1:0]                         lzc_next;
  logic                               neg;
  logic                               neg_next;
  pip_pkg::status_t                   err;
  pip_pkg::status_t                   err_next;
  logic                               seen;
  logic                               seen_next;

  // Result register
  logic                               out_valid;
  logic [VW-1:0]                      value_q;
  logic [VW-1:0]                      value_next;
  pip_pkg::status_t                   status_q;
  pip_pkg::status_t                   status_next;

  logic                               is_term;
  logic                               advance;
  logic                               load_result;

  logic                               is_dec;
  logic                               is_lhex;
  logic                               is_uhex;
  logic                               is_digit;
  logic [pip_pkg::DIGIT_WIDTH-1:0]    digit;
  logic [SW-1:0]                      acc_ext;
  logic [SW-1:0]                      scaled;
  logic [SW-1:0]                      sum;
  logic [SW-1:0]                      limit;
  logic                               overflow;
  logic [VW-1:0]                      sum_low;

  // Handshake: a zero byte waits for a free result slot
  assign is_term     = (char_q == pip_pkg::CHAR_NUL);
  assign advance     = in_valid && (!is_term || !out_valid || result.ready);
  assign load_result = advance && is_term;
  assign text.ready  = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (text.ready) begin
      in_valid <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.ready && text.valid) begin
      char_q <= text.character;
    end
  end

  // Classify the byte and find its digit value in the current radix
  always_comb begin
    is_dec  = (char_q >= pip_pkg::CHAR_ZERO) && (char_q <= pip_pkg::CHAR_NINE);
    is_lhex = (char_q >= pip_pkg::CHAR_LC_A) && (char_q <= pip_pkg::CHAR_LC_F);
    is_uhex = (char_q >= pip_pkg::CHAR_UC_A) && (char_q <= pip_pkg::CHAR_UC_F);
    if (is_dec) begin
      digit = pip_pkg::DIGIT_WIDTH'(char_q - pip_pkg::CHAR_ZERO);
    end else if (is_lhex) begin
      digit = pip_pkg::DIGIT_WIDTH'(char_q - pip_pkg::CHAR_LC_A + 8'd10);
    end else begin
      digit = pip_pkg::DIGIT_WIDTH'(char_q - pip_pkg::CHAR_UC_A + 8'd10);
    end
    case (radix)
      pip_pkg::RADIX_DEC: is_digit = is_dec;
      pip_pkg::RADIX_OCT: is_digit = is_dec && (digit < 4'd8);
      pip_pkg::RADIX_BIN: is_digit = is_dec && (digit < 4'd2);
      pip_pkg::RADIX_HEX: is_digit = is_dec || is_lhex || is_uhex;
      default:            is_digit = 1'b0;
    endcase
  end

  // Multiply by the radix with shifts, add the digit, check the signed range
  always_comb begin
    acc_ext = {{pip_pkg::GUARD_WIDTH{1'b0}}, acc};
    case (radix)
      pip_pkg::RADIX_DEC: scaled = (acc_ext << 3) + (acc_ext << 1);
      pip_pkg::RADIX_OCT: scaled = acc_ext << 3;
      pip_pkg::RADIX_HEX: scaled = acc_ext << 4;
      pip_pkg::RADIX_BIN: scaled = acc_ext << 1;
      default:            scaled = acc_ext;
    endcase
    sum      = scaled + {{(SW - pip_pkg::DIGIT_WIDTH){1'b0}}, digit};
    limit    = {{(pip_pkg::GUARD_WIDTH + 1){1'b0}}, {(VW - 1){1'b1}}}
               + {{(SW - 1){1'b0}}, neg};
    overflow = (sum > limit);
    sum_low  = sum[VW-1:0];
  end

  // Next parse state and result
  always_comb begin
    acc_next    = acc;
    radix_next  = radix;
    lzc_next    = lzc;
    neg_next    = neg;
    err_next    = err;
    seen_next   = seen;
    value_next  = '0;
    status_next = pip_pkg::STATUS_OK;

    if (is_term) begin
      if (!seen) begin
        status_next = pip_pkg::STATUS_EMPTY;
      end else if (err != pip_pkg::STATUS_OK) begin
        status_next = err;
      end else if (neg && (acc == '0) && (lzc == 2'd0)) begin
        status_next = pip_pkg::STATUS_BAD_CHAR;
      end else begin
        value_next = neg ? ({VW{1'b0}} - acc) : acc;
      end
      acc_next   = '0;
      radix_next = pip_pkg::RADIX_DEC;
      lzc_next   = 2'd0;
      neg_next   = 1'b0;
      err_next   = pip_pkg::STATUS_OK;
      seen_next  = 1'b0;
    end else begin
      seen_next = 1'b1;
      if (err == pip_pkg::STATUS_OK) begin
        if (!is_digit) begin
          if ((char_q == pip_pkg::CHAR_MINUS) && !seen) begin
            neg_next = 1'b1;
          end else if ((lzc == 2'd1) && (radix == pip_pkg::RADIX_DEC) &&
                       ((char_q == pip_pkg::CHAR_LC_B) ||
                        (char_q == pip_pkg::CHAR_UC_B))) begin
            radix_next = pip_pkg::RADIX_BIN;
          end else if ((lzc == 2'd1) && (radix == pip_pkg::RADIX_DEC) &&
                       ((char_q == pip_pkg::CHAR_LC_X) ||
                        (char_q == pip_pkg::CHAR_UC_X))) begin
            radix_next = pip_pkg::RADIX_HEX;
          end else begin
            err_next = pip_pkg::STATUS_BAD_CHAR;
          end
        end else if (overflow) begin
          err_next = pip_pkg::STATUS_OVERFLOW;
        end else begin
          acc_next = sum_low;
          if (sum_low == '0) begin
            if (lzc != 2'd2) begin
              lzc_next = lzc + 2'd1;
            end
          end else if ((acc == '0) && (radix == pip_pkg::RADIX_DEC) &&
                       (lzc == 2'd1)) begin
            // single leading zero then a nonzero digit: octal
            radix_next = pip_pkg::RADIX_OCT;
            if (digit > 4'd7) begin
              err_next = pip_pkg::STATUS_BAD_CHAR;
            end
          end
        end
      end
    end
  end

  // Advance the parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= '0;
      radix <= pip_pkg::RADIX_DEC;
      lzc   <= 2'd0;
      neg   <= 1'b0;
      err   <= pip_pkg::STATUS_OK;
      seen  <= 1'b0;
    end else if (advance) begin
      acc   <= acc_next;
      radix <= radix_next;
      lzc   <= lzc_next;
      neg   <= neg_next;
      err   <= err_next;
      seen  <= seen_next;
    end
  end

  // Hold the result until its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_result) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      value_q  <= value_next;
      status_q <= status_next;
    end
  end

  assign result.valid  = out_valid;
  assign result.value  = value_q;
  assign result.status = status_q;

`ifndef SYNTHESIS
  // A result clears the parse state for the next string
  assert property (@(posedge clk) disable iff (rst)
    load_result |=> (acc == '0) && !seen && (err == pip_pkg::STATUS_OK) && !neg)
    else $error("parse state not cleared after result");

  // A prefix or octal switch needs a byte of the current string
  assert property (@(posedge clk) disable iff (rst)
    (radix != pip_pkg::RADIX_DEC) |-> seen)
    else $error("radix changed with no byte seen");

  // A failed parse reports zero
  assert property (@(posedge clk) disable iff (rst)
    (result.valid && (result.status != pip_pkg::STATUS_OK)) |-> (result.value == '0))
    else $error("nonzero value with error status");

  // A byte stuck in the input register stays put
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> (in_valid && $stable(char_q)))
    else $error("pending byte lost or changed");
`endif

endmodule

/* bench/tb_prefixed_integer_parser.sv */
// Self-checking bench for the prefixed integer parser: directed strings, then random text.
`timescale 1ns / 100ps

module tb_prefixed_integer_parser;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 6;
  localparam int RANDOM_CHARS = 800;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_AFTER   = 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 200_000;

  typedef struct packed {
    logic signed [pip_pkg::VALUE_WIDTH-1:0] value;
    pip_pkg::status_t                       status;
  } parse_result_t;

  typedef struct {
    string         text;
    bit            typed;
    parse_result_t answer;
  } text_case_t;

  logic clk = 1'b0;
  logic rst;

  pip_char_if   text_ch ();
  pip_result_if result_ch ();

  prefixed_integer_parser dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .result (result_ch)
  );

  always #CLK_HALF clk = ~clk;

  // Directed strings; typed answers only where they are obvious
  text_case_t directed_cases [25] = '{
    '{"",            1'b1, '{0, pip_pkg::STATUS_EMPTY}},
    '{"0",           1'b1, '{0, pip_pkg::STATUS_OK}},
    '{"2147483647",  1'b1, '{32'sd2147483647, pip_pkg::STATUS_OK}},
    '{"2147483648",  1'b1, '{0, pip_pkg::STATUS_OVERFLOW}},
    '{"-2147483648", 1'b1, '{32'h8000_0000, pip_pkg::STATUS_OK}},
    '{"-2147483649", 1'b1, '{0, pip_pkg::STATUS_OVERFLOW}},
    '{"-",           1'b1, '{0, pip_pkg::STATUS_BAD_CHAR}},
    '{"-0",          1'b0, '{0, pip_pkg::STATUS_OK}},
    '{"5-",          1'b1, '{0, pip_pkg::STATUS_BAD_CHAR}},
    '{"0x",          1'b1, '{0, pip_pkg::STATUS_OK}},
    '{"0x7fffffff",  1'b1, '{32'sd2147483647, pip_pkg::STATUS_OK}},
    '{"0X80000000",  1'b1, '{0, pip_pkg::STATUS_OVERFLOW}},
    '{"-0x80000000", 1'b1, '{32'h8000_0000, pip_pkg::STATUS_OK}},
    '{"0b1011",      1'b0, '{0, pip_pkg::STATUS_OK}},
    '{"0B",          1'b0, '{0, pip_pkg::STATUS_OK}},
    '{"017",         1'b0, '{0, pip_pkg::STATUS_OK}},
    '{"08",          1'b1, '{0, pip_pkg::STATUS_BAD_CHAR}},
    '{"007",         1'b0, '{0, pip_pkg::STATUS_OK}},
    '{"00x5",        1'b1, '{0, pip_pkg::STATUS_BAD_CHAR}},
    '{"1x",          1'b1, '{0, pip_pkg::STATUS_BAD_CHAR}},
    '{"0xAbCdEf",    1'b0, '{0, pip_pkg::STATUS_OK}},
    '{"0b2",         1'b1, '{0, pip_pkg::STATUS_BAD_CHAR}},
    '{"12z3-",       1'b1, '{0, pip_pkg::STATUS_BAD_CHAR}},
    '{"9\377",       1'b1, '{0, pip_pkg::STATUS_BAD_CHAR}},
    '{"99999999999", 1'b1, '{0, pip_pkg::STATUS_OVERFLOW}}
  };

  // Parse state of the predictor
  longint unsigned  acc_mag        = 0;
  pip_pkg::radix_t  radix_now      = pip_pkg::RADIX_DEC;
  int               zero_digits    = 0;
  bit               minus_seen     = 1'b0;
  pip_pkg::status_t latched_status = pip_pkg::STATUS_OK;
  bit               any_char       = 1'b0;

  parse_result_t expected_results [$];

  int errors        = 0;
  int chars_sent    = 0;
  int strings_sent  = 0;
  int input_stalls  = 0;
  int burst_left    = 0;
  int results_seen  = 0;
  int status_tally [4] = '{0, 0, 0, 0};
  int hold_left     = 0;
  bit hold_done     = 1'b0;
  int ready_mode    = 0;
  int pattern_left  = 0;
  int cycle_count   = 0;

  function automatic longint unsigned radix_base(pip_pkg::radix_t r);
    case (r)
      pip_pkg::RADIX_OCT: return 8;
      pip_pkg::RADIX_HEX: return 16;
      pip_pkg::RADIX_BIN: return 2;
      default:            return 10;
    endcase
  endfunction

  // Digit value of a byte in the given radix, -1 when it is no digit there
  function automatic int char_digit(pip_pkg::radix_t r, logic [pip_pkg::CHAR_WIDTH-1:0] c);
    int d;
    d = -1;
    if (c >= pip_pkg::CHAR_ZERO && c <= pip_pkg::CHAR_NINE) begin
      if (longint'(c - pip_pkg::CHAR_ZERO) < radix_base(r)) d = int'(c - pip_pkg::CHAR_ZERO);
    end else if (r == pip_pkg::RADIX_HEX) begin
      if (c >= pip_pkg::CHAR_LC_A && c <= pip_pkg::CHAR_LC_F)
        d = int'(c - pip_pkg::CHAR_LC_A) + 10;
      else if (c >= pip_pkg::CHAR_UC_A && c <= pip_pkg::CHAR_UC_F)
        d = int'(c - pip_pkg::CHAR_UC_A) + 10;
    end
    return d;
  endfunction

  // Fold one nonzero byte into the parse state
  function automatic void fold_char(logic [pip_pkg::CHAR_WIDTH-1:0] c);
    bit              first;
    int              d;
    longint unsigned base;
    longint unsigned ceiling;
    longint unsigned prev;
    first    = !any_char;
    any_char = 1'b1;
    if (latched_status != pip_pkg::STATUS_OK) return;
    d = char_digit(radix_now, c);
    if (d < 0) begin
      if (c == pip_pkg::CHAR_MINUS && first) begin
        minus_seen = 1'b1;
      end else if (zero_digits == 1 && radix_now == pip_pkg::RADIX_DEC &&
                   (c == pip_pkg::CHAR_LC_B || c == pip_pkg::CHAR_UC_B)) begin
        radix_now = pip_pkg::RADIX_BIN;
      end else if (zero_digits == 1 && radix_now == pip_pkg::RADIX_DEC &&
                   (c == pip_pkg::CHAR_LC_X || c == pip_pkg::CHAR_UC_X)) begin
        radix_now = pip_pkg::RADIX_HEX;
      end else begin
        latched_status = pip_pkg::STATUS_BAD_CHAR;
      end
      return;
    end
    // Checked multiply-add; negative values may reach one further
    base    = radix_base(radix_now);
    ceiling = (64'd1 << (pip_pkg::VALUE_WIDTH - 1)) - 1 + longint'(minus_seen);
    if (acc_mag > (ceiling - longint'(d)) / base) begin
      latched_status = pip_pkg::STATUS_OVERFLOW;
      return;
    end
    prev    = acc_mag;
    acc_mag = acc_mag * base + longint'(d);
    if (acc_mag == 0) begin
      if (zero_digits < 2) zero_digits++;
    end else if (prev == 0 && radix_now == pip_pkg::RADIX_DEC && zero_digits == 1) begin
      radix_now = pip_pkg::RADIX_OCT;
      if (d > 7) latched_status = pip_pkg::STATUS_BAD_CHAR;
    end
  endfunction

  // Produce the result of a terminated string and clear the parse state
  function automatic parse_result_t close_string();
    parse_result_t r;
    r.value = '0;
    if (!any_char) r.status = pip_pkg::STATUS_EMPTY;
    else if (latched_status != pip_pkg::STATUS_OK) r.status = latched_status;
    else if (minus_seen && acc_mag == 0 && zero_digits == 0)
      r.status = pip_pkg::STATUS_BAD_CHAR;
    else begin
      r.status = pip_pkg::STATUS_OK;
      r.value  = acc_mag[pip_pkg::VALUE_WIDTH-1:0];
      if (minus_seen) r.value = -r.value;
    end
    acc_mag        = 0;
    radix_now      = pip_pkg::RADIX_DEC;
    zero_digits    = 0;
    minus_seen     = 1'b0;
    latched_status = pip_pkg::STATUS_OK;
    any_char       = 1'b0;
    return r;
  endfunction

  // A number in some radix, optionally signed, near the limits now and then
  function automatic string wellformed_text();
    longint unsigned mag;
    pip_pkg::radix_t r;
    string           head;
    string           body;
    r = pip_pkg::radix_t'($urandom_range(0, 3));
    if ($urandom_range(0, 9) == 0) mag = 64'h7fff_ffff + $urandom_range(0, 2);
    else mag = {32'($urandom_range(0, 3)), 32'($urandom)} >> $urandom_range(0, 33);
    case (r)
      pip_pkg::RADIX_DEC: begin
        head = "";
        body = $sformatf("%0d", mag);
      end
      pip_pkg::RADIX_OCT: begin
        head = "0";
        body = $sformatf("%0o", mag);
      end
      pip_pkg::RADIX_HEX: begin
        head = $urandom_range(0, 1) ? "0x" : "0X";
        body = $sformatf("%0h", mag);
        if ($urandom_range(0, 1)) body = body.toupper();
      end
      default: begin
        head = $urandom_range(0, 1) ? "0b" : "0B";
        body = $sformatf("%0b", mag);
      end
    endcase
    if ($urandom_range(0, 2) == 0) head = {"-", head};
    return {head, body};
  endfunction

  // Mostly well-formed numbers, some with one byte corrupted, some noise, now and then an empty string
  function automatic string random_text();
    string s;
    int    pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return wellformed_text();
    if (pick < 85) begin
      s = wellformed_text();
      s[$urandom_range(0, s.len() - 1)] =
        ($urandom_range(0, 3) == 0) ? pip_pkg::CHAR_MINUS : 8'($urandom_range(1, 255));
      return s;
    end
    if (pick < 96) begin
      s = "";
      repeat ($urandom_range(1, 6)) s = $sformatf("%s%c", s, 8'($urandom_range(1, 255)));
      return s;
    end
    return "";
  endfunction

  // Hold one byte on the channel until it transfers
  task automatic offer(input logic [pip_pkg::CHAR_WIDTH-1:0] c);
    text_ch.valid     <= 1'b1;
    text_ch.character <= c;
    @(posedge clk);
    while (!text_ch.ready) begin
      input_stalls++;
      @(posedge clk);
    end
    chars_sent++;
  endtask

  // Bursts of random length, random gaps between them, some stretches gap-free
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(1, 24);
    gap = ((chars_sent % 320) < 80) ? 0 : $urandom_range(1, 8);
    if (gap != 0) begin
      text_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_text(input string s, input bit typed, input parse_result_t answer);
    parse_result_t predicted;
    for (int i = 0; i < s.len(); i++) begin
      offer(s[i]);
      fold_char(s[i]);
      pace();
    end
    offer(pip_pkg::CHAR_NUL);
    predicted = close_string();
    expected_results.push_back(typed ? answer : predicted);
    strings_sent++;
    pace();
  endtask

  // Receiver: check each transfer, stall on a pattern, hold off once for long
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result value %0d status %0d", $time,
                   result_ch.value, result_ch.status);
          errors++;
        end else begin
          if (result_ch.value !== expected_results[0].value) begin
            $display("%0t: value mismatch: expected %0d, actual %0d", $time,
                     expected_results[0].value, result_ch.value);
            errors++;
          end
          if (result_ch.status !== expected_results[0].status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                     expected_results[0].status, result_ch.status);
            errors++;
          end
          void'(expected_results.pop_front());
        end
        status_tally[result_ch.status]++;
        results_seen++;
      end
      if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        if (pattern_left == 0) begin
          ready_mode   = $urandom_range(0, 3);
          pattern_left = $urandom_range(20, 80);
        end
        pattern_left--;
        case (ready_mode)
          0:       result_ch.ready <= 1'b1;
          1:       result_ch.ready <= ($urandom_range(0, 3) != 0);
          2:       result_ch.ready <= ($urandom_range(0, 3) == 0);
          default: result_ch.ready <= !result_ch.ready;
        endcase
      end
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int random_start;
    rst               = 1'b1;
    text_ch.valid     = 1'b0;
    text_ch.character = '0;
    result_ch.ready   = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_cases[i])
      send_text(directed_cases[i].text, directed_cases[i].typed, directed_cases[i].answer);

    random_start = chars_sent;
    while (chars_sent - random_start < RANDOM_CHARS) send_text(random_text(), 1'b0, '0);
    text_ch.valid <= 1'b0;

    // Drain outstanding results, then watch for strays
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d strings in %0d bytes, %0d input stall cycles", strings_sent,
             chars_sent, input_stalls);
    $display("Results: ok %0d, bad char %0d, overflow %0d, empty %0d", status_tally[0],
             status_tally[1], status_tally[2], status_tally[3]);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
design/pip_pkg.sv
design/pip_char_if.sv
design/pip_result_if.sv
design/prefixed_integer_parser.sv
bench/tb_prefixed_integer_parser.sv
